[design/dkwp_pkg.sv]
// ----------------------------------------------------------------------------
// dkwp_pkg
// Shared types and constants for the k-mer window packer: window geometry,
// nucleotide code values and the decoded-code record.
// ----------------------------------------------------------------------------
package dkwp_pkg;

    // Window size in 32-bit words (1 or 2).
    localparam int WINDOW_WORDS = 2;
    localparam int WINDOW_W     = WINDOW_WORDS * 32;
    localparam int PACKED_W     = 64;
    localparam int CHAR_W       = 8;
    localparam int CODE_W       = 4;

    typedef logic [PACKED_W-1:0] t_packed;
    typedef logic [WINDOW_W-1:0] t_window;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [CODE_W-1:0]   t_code;

    // 2-bit ACGT codes.
    localparam logic [1:0] NARROW_A = 2'd0;
    localparam logic [1:0] NARROW_C = 2'd1;
    localparam logic [1:0] NARROW_G = 2'd2;
    localparam logic [1:0] NARROW_T = 2'd3;

    // 4-bit IUPAC codes, one bit per base.
    localparam t_code IUPAC_A = 4'd1;
    localparam t_code IUPAC_C = 4'd2;
    localparam t_code IUPAC_M = 4'd3;
    localparam t_code IUPAC_G = 4'd4;
    localparam t_code IUPAC_R = 4'd5;
    localparam t_code IUPAC_S = 4'd6;
    localparam t_code IUPAC_V = 4'd7;
    localparam t_code IUPAC_T = 4'd8;
    localparam t_code IUPAC_W = 4'd9;
    localparam t_code IUPAC_Y = 4'd10;
    localparam t_code IUPAC_H = 4'd11;
    localparam t_code IUPAC_K = 4'd12;
    localparam t_code IUPAC_D = 4'd13;
    localparam t_code IUPAC_B = 4'd14;
    localparam t_code IUPAC_N = 4'd15;

    // Result of the character lookup.
    typedef struct packed {
        logic  valid;
        t_code code;
    } t_lookup;

endpackage

[design/dkwp_code_map.sv]
// ----------------------------------------------------------------------------
// dkwp_code_map
// Maps one ASCII nucleotide character to its 2-bit or 4-bit code.
// ----------------------------------------------------------------------------
module dkwp_code_map (
    input  dkwp_pkg::t_char   i_char,
    input  logic              i_four_bit_mode,
    output dkwp_pkg::t_lookup o_lookup
);

    dkwp_pkg::t_lookup narrow;
    dkwp_pkg::t_lookup wide;

    always_comb begin
        narrow.valid = 1'b1;
        narrow.code  = '0;
        case (i_char)
            "A", "a": narrow.code = {2'b00, dkwp_pkg::NARROW_A};
            "C", "c": narrow.code = {2'b00, dkwp_pkg::NARROW_C};
            "G", "g": narrow.code = {2'b00, dkwp_pkg::NARROW_G};
            "T", "t": narrow.code = {2'b00, dkwp_pkg::NARROW_T};
            default:  narrow.valid = 1'b0;
        endcase
    end

    always_comb begin
        wide.valid = 1'b1;
        wide.code  = '0;
        case (i_char)
            "A", "a":           wide.code = dkwp_pkg::IUPAC_A;
            "C", "c":           wide.code = dkwp_pkg::IUPAC_C;
            "G", "g":           wide.code = dkwp_pkg::IUPAC_G;
            "T", "t", "U", "u": wide.code = dkwp_pkg::IUPAC_T;
            // The fully ambiguous symbols are recognised in upper case only.
            "N", "X", "-":      wide.code = dkwp_pkg::IUPAC_N;
            "W", "w":           wide.code = dkwp_pkg::IUPAC_W;
            "S", "s":           wide.code = dkwp_pkg::IUPAC_S;
            "M", "m":           wide.code = dkwp_pkg::IUPAC_M;
            "K", "k":           wide.code = dkwp_pkg::IUPAC_K;
            "R", "r":           wide.code = dkwp_pkg::IUPAC_R;
            "Y", "y":           wide.code = dkwp_pkg::IUPAC_Y;
            "B", "b":           wide.code = dkwp_pkg::IUPAC_B;
            "D", "d":           wide.code = dkwp_pkg::IUPAC_D;
            "H", "h":           wide.code = dkwp_pkg::IUPAC_H;
            "V", "v":           wide.code = dkwp_pkg::IUPAC_V;
            default:            wide.valid = 1'b0;
        endcase
    end

    assign o_lookup = i_four_bit_mode ? wide : narrow;

endmodule

[design/dkwp_window.sv]
// ----------------------------------------------------------------------------
// dkwp_window
// Window shift register and result register with its output handshake.
// ----------------------------------------------------------------------------
module dkwp_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_four_bit_mode,
    input  dkwp_pkg::t_lookup     i_lookup,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output dkwp_pkg::t_packed     o_m_axis_tdata,
    output logic                  o_m_axis_tuser
);

    dkwp_pkg::t_window r_window;
    dkwp_pkg::t_window n_window;
    dkwp_pkg::t_window shifted;
    logic              r_out_valid;
    dkwp_pkg::t_packed r_out_data;
    logic              r_out_invalid;
    logic              load;

    assign o_ready = !r_out_valid || i_m_axis_tready;
    assign load    = i_valid && o_ready;

    always_comb begin
        if (i_four_bit_mode) begin
            shifted = {r_window[dkwp_pkg::WINDOW_W-5:0], i_lookup.code};
        end else begin
            shifted = {r_window[dkwp_pkg::WINDOW_W-3:0], i_lookup.code[1:0]};
        end
        // An unmapped character leaves the window as it was.
        n_window = i_lookup.valid ? shifted : r_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_window <= n_window;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data    <= dkwp_pkg::t_packed'(n_window);
            r_out_invalid <= !i_lookup.valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_invalid;

endmodule

[design/dna_kmer_window_packer.sv]
// ----------------------------------------------------------------------------
// dna_kmer_window_packer
// Packs a stream of nucleotide characters into a sliding k-mer window.
// ----------------------------------------------------------------------------
// Usage: each slave-side item carries one ASCII character in tdata[7:0].
// The character is decoded to a 2-bit ACGT code or, with four_bit_mode set,
// to a 4-bit IUPAC code, and shifted into the low bits of the window. Each
// item yields one master-side item: tdata holds the whole window after the
// push (bits above the window width read zero) and tuser flags a character
// that has no code in the current mode, in which case the window is kept.
// The result passes through the input register, then decode and shift into
// the result register. Throughput is one item per clock while the receiver
// does not stall; the single window register closes the loop from one item
// to the next. Reset clears the window, the mode register and both stage
// valid flags. When the receiver stalls, the result register holds, the input
// register fills behind it, and only then is the slave-side tready dropped.
// four_bit_mode is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dna_kmer_window_packer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  dkwp_pkg::t_char       i_s_axis_tdata,  // [7:0] base_char
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output dkwp_pkg::t_packed     o_m_axis_tdata,  // [63:0] packed_window
    output logic                  o_m_axis_tuser   // [0] invalid_char
);

    logic              r_four_bit_mode;
    logic              r_in_valid;
    dkwp_pkg::t_char   r_in_char;
    logic              stage_ready;
    dkwp_pkg::t_lookup lookup;

    assign o_s_axis_tready = !r_in_valid || stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit_mode <= 1'b0;
            r_in_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_four_bit_mode <= i_cfg_wr_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
        end
    end

    dkwp_code_map u_code_map (
        .i_char          (r_in_char),
        .i_four_bit_mode (r_four_bit_mode),
        .o_lookup        (lookup)
    );

    dkwp_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .o_ready         (stage_ready),
        .i_four_bit_mode (r_four_bit_mode),
        .i_lookup        (lookup),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

[design/dkwp_checker.sv]
// ----------------------------------------------------------------------------
// dkwp_checker
// Port-level checks for the k-mer window packer, bound to the top level.
// ----------------------------------------------------------------------------
module dkwp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_s_axis_tready,
    input  logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  dkwp_pkg::t_packed o_m_axis_tdata,
    input  logic              o_m_axis_tuser
);

    dkwp_pkg::t_packed r_last_window;
    logic              out_take;

    assign out_take = o_m_axis_tvalid && i_m_axis_tready;

    // Window shown by the most recently delivered result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_window <= '0;
        end else if (out_take) begin
            r_last_window <= o_m_axis_tdata;
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid directly after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result item changed");

    a_invalid_keeps_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_m_axis_tuser |-> o_m_axis_tdata == r_last_window)
        else $error("invalid character altered the window");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty result register");

endmodule

bind dna_kmer_window_packer dkwp_checker u_dkwp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
